>>> design/fccw_pkg.sv
// Shared types, constants and helpers for the FAT12 cluster chain walker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fccw_pkg;

    localparam int FAT_BYTES_DEF = 8192;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_BPS     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPC     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESV    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COPIES  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPF     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROOT    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL   = 3'd6;

    localparam logic [12:0] BPS_RST    = 13'd512;
    localparam logic [7:0]  SPC_RST    = 8'd1;
    localparam logic [15:0] RESV_RST   = 16'd1;
    localparam logic [7:0]  COPIES_RST = 8'd2;
    localparam logic [15:0] SPF_RST    = 16'd9;
    localparam logic [15:0] ROOT_RST   = 16'd224;
    localparam logic [15:0] TOTAL_RST  = 16'd2880;

    localparam logic [7:0]  SPC_MAX = 8'd128;

    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_START   = 2'd1;
    localparam logic [1:0] ACT_ADVANCE = 2'd2;

    localparam logic [11:0] CLUSTER_FIRST    = 12'h002;
    localparam logic [11:0] CLUSTER_LAST_MAX = 12'hFEF;
    localparam logic [11:0] CLUSTER_EOC_LO   = 12'hFF8;

    localparam int DIV_N_W = 21;
    localparam int DIV_D_W = 13;

    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;

    typedef struct packed {
        logic load_in;
        logic mem_wr;
        logic rd_lo;
        logic rd_hi;
        logic set_start;
        logic step_in;
        logic set_next;
        logic mul;
        logic add;
        logic out_load;
        logic geo_mul;
        logic div_start;
        logic div_sel;
        logic geo_first;
        logic geo_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       in_cluster;
        logic       div_done;
        logic       out_free;
    } dp_stat_t;

    // Byte index modulo the store size; index < 8192 and size >= 512.
    function automatic logic [13:0] fat_wrap(input logic [13:0] idx, input logic [13:0] size);
        logic [16:0] r;
        logic [16:0] sub;
        r = {3'b000, idx};
        for (int k = 3; k >= 0; k--)
        begin
            sub = {3'b000, size} << k;
            if (r >= sub)
            begin
                r = r - sub;
            end
        end
        return r[13:0];
    endfunction

endpackage

>>> design/fccw_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on fccw_pkg for operand widths.
`timescale 1ns / 1ps

module fccw_div
    import fccw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic [DIV_N_W-1:0] quotient,
    output logic               done
);

    localparam int CNT_W = $clog2(DIV_N_W);

    logic [DIV_N_W-1:0] quo_reg, quo_next;
    logic [DIV_D_W-1:0] rem_reg, rem_next;
    logic [DIV_D_W-1:0] dvs_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [DIV_D_W:0]   shifted;
    logic [DIV_D_W:0]   diff;
    logic               ge;

    assign shifted = {rem_reg, quo_reg[DIV_N_W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next = ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
        quo_next = {quo_reg[DIV_N_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIV_N_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

>>> design/fccw_ctrl.sv
// Controller FSM: geometry setup sequence and per-beat dispatch.
// Depends on fccw_pkg for command/status structs and codes.
`timescale 1ns / 1ps

module fccw_ctrl
    import fccw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_axis_tvalid,
    output logic      s_axis_tready,
    input  logic      cfg_we,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_GEO_MUL   = 4'd1;
    localparam logic [3:0] ST_GEO_DIV1  = 4'd2;
    localparam logic [3:0] ST_GEO_FIRST = 4'd3;
    localparam logic [3:0] ST_GEO_D2S   = 4'd4;
    localparam logic [3:0] ST_GEO_DIV2  = 4'd5;
    localparam logic [3:0] ST_GEO_LAST  = 4'd6;
    localparam logic [3:0] ST_DISPATCH  = 4'd7;
    localparam logic [3:0] ST_RD_LO     = 4'd8;
    localparam logic [3:0] ST_RD_HI     = 4'd9;
    localparam logic [3:0] ST_NEXT      = 4'd10;
    localparam logic [3:0] ST_MUL       = 4'd11;
    localparam logic [3:0] ST_ADD       = 4'd12;
    localparam logic [3:0] ST_OUT       = 4'd13;

    logic [3:0] state_reg, state_next;
    logic       dirty_reg;
    logic       in_ready;
    logic       accept;

    assign in_ready      = (state_reg == ST_IDLE) && !dirty_reg && !cfg_we;
    assign accept        = s_axis_tvalid && in_ready;
    assign s_axis_tready = in_ready;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.load_in = accept;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DISPATCH;
                end
                else if (dirty_reg && !cfg_we)
                begin
                    state_next = ST_GEO_MUL;
                end
            end
            ST_GEO_MUL:
            begin
                cmd.geo_mul   = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b0;
                state_next    = ST_GEO_DIV1;
            end
            ST_GEO_DIV1:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_GEO_FIRST;
                end
            end
            ST_GEO_FIRST:
            begin
                cmd.geo_first = 1'b1;
                state_next    = ST_GEO_D2S;
            end
            ST_GEO_D2S:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = ST_GEO_DIV2;
            end
            ST_GEO_DIV2:
            begin
                cmd.div_sel = 1'b1;
                if (stat.div_done)
                begin
                    state_next = ST_GEO_LAST;
                end
            end
            ST_GEO_LAST:
            begin
                cmd.geo_last = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_DISPATCH:
            begin
                unique case (stat.action)
                    ACT_LOAD:
                    begin
                        cmd.mem_wr = 1'b1;
                        state_next = ST_IDLE;
                    end
                    ACT_START:
                    begin
                        cmd.set_start = 1'b1;
                        state_next    = ST_MUL;
                    end
                    ACT_ADVANCE:
                    begin
                        if (stat.in_cluster)
                        begin
                            cmd.step_in = 1'b1;
                            state_next  = ST_OUT;
                        end
                        else
                        begin
                            state_next = ST_RD_LO;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_RD_LO:
            begin
                cmd.rd_lo  = 1'b1;
                state_next = ST_RD_HI;
            end
            ST_RD_HI:
            begin
                cmd.rd_hi  = 1'b1;
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                cmd.set_next = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dirty_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                dirty_reg <= 1'b1;
            end
            else if (cmd.geo_mul)
            begin
                dirty_reg <= 1'b0;
            end
        end
    end

endmodule

>>> design/fccw_dp.sv
// Datapath: geometry registers, FAT byte store, position registers, output stage.
// Depends on fccw_pkg and fccw_div.
`timescale 1ns / 1ps

module fccw_dp
    import fccw_pkg::*;
#(
    parameter int FAT_BYTES = FAT_BYTES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    input  logic [IN_USER_W-1:0]   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  ctrl_cmd_t              cmd,
    output dp_stat_t               stat
);

    localparam int AW = $clog2(FAT_BYTES);

    logic [12:0] bps_reg;
    logic [7:0]  spc_reg;
    logic [15:0] resv_reg;
    logic [7:0]  copies_reg;
    logic [15:0] spf_reg;
    logic [15:0] root_reg;
    logic [15:0] total_reg;

    logic [1:0]  act_reg;
    logic [12:0] addr_reg;
    logic [7:0]  byte_reg;
    logic [11:0] start_reg;

    logic [11:0] cluster_reg;
    logic [6:0]  sic_reg;
    logic [24:0] sector_reg;

    logic [23:0] cs_prod_reg;
    logic [24:0] first_reg;
    logic [24:0] base_reg;
    logic [11:0] last_reg;
    logic [19:0] prod_reg;

    logic [7:0]  fat_mem [FAT_BYTES];
    logic [7:0]  rd_data_reg;
    logic [7:0]  lo_byte_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [7:0]         spc_eff;
    logic [12:0]        bps_eff;
    logic [DIV_N_W-1:0] div_n;
    logic [DIV_D_W-1:0] div_d;
    logic [DIV_N_W-1:0] quot;
    logic               div_done;
    logic [15:0]        data_sectors;
    logic [16:0]        last_raw;
    logic [13:0]        lo_idx;
    logic [13:0]        hi_idx;
    logic [13:0]        lo_wrap;
    logic [13:0]        hi_wrap;
    logic [AW-1:0]      rd_addr;
    logic               wr_ok;
    logic [11:0]        next_cluster;
    logic [7:0]         sic_inc;
    logic               eoc;
    logic               readable;

    always_comb
    begin
        if (spc_reg == 8'd0)
        begin
            spc_eff = 8'd1;
        end
        else if (spc_reg > SPC_MAX)
        begin
            spc_eff = SPC_MAX;
        end
        else
        begin
            spc_eff = spc_reg;
        end
    end

    assign bps_eff = (bps_reg == 13'd0) ? 13'd1 : bps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bps_reg    <= BPS_RST;
            spc_reg    <= SPC_RST;
            resv_reg   <= RESV_RST;
            copies_reg <= COPIES_RST;
            spf_reg    <= SPF_RST;
            root_reg   <= ROOT_RST;
            total_reg  <= TOTAL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BPS:    bps_reg    <= cfg_data[12:0];
                CFG_SPC:    spc_reg    <= cfg_data[7:0];
                CFG_RESV:   resv_reg   <= cfg_data;
                CFG_COPIES: copies_reg <= cfg_data[7:0];
                CFG_SPF:    spf_reg    <= cfg_data;
                CFG_ROOT:   root_reg   <= cfg_data;
                CFG_TOTAL:  total_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Geometry: first = reserved + copies*spf + root*32/bps
    assign div_n = cmd.div_sel ? {5'b00000, data_sectors} : {root_reg, 5'b00000};
    assign div_d = cmd.div_sel ? {5'b00000, spc_eff} : bps_eff;

    fccw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .quotient (quot),
        .done     (div_done)
    );

    assign data_sectors = (first_reg > {9'd0, total_reg}) ? 16'd0
                                                          : total_reg - first_reg[15:0];
    assign last_raw     = {1'b0, quot[15:0]} + 17'd1;

    always_ff @(posedge clk)
    begin
        if (cmd.geo_mul)
        begin
            cs_prod_reg <= {16'd0, copies_reg} * {8'd0, spf_reg};
        end
        if (cmd.geo_first)
        begin
            first_reg <= {9'd0, resv_reg} + {1'b0, cs_prod_reg} + {4'd0, quot};
        end
        if (cmd.geo_last)
        begin
            last_reg <= (last_raw > {5'd0, CLUSTER_LAST_MAX}) ? CLUSTER_LAST_MAX
                                                              : last_raw[11:0];
            base_reg <= first_reg - {16'd0, spc_eff, 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            act_reg   <= s_axis_tuser;
            addr_reg  <= s_axis_tdata[12:0];
            byte_reg  <= s_axis_tdata[20:13];
            start_reg <= s_axis_tdata[32:21];
        end
    end

    // FAT entry bytes at 3c/2 and 3c/2+1, wrapped to the store size
    assign lo_idx  = {2'b00, cluster_reg} + {3'b000, cluster_reg[11:1]};
    assign hi_idx  = lo_idx + 14'd1;
    assign lo_wrap = fat_wrap(lo_idx, 14'(FAT_BYTES));
    assign hi_wrap = fat_wrap(hi_idx, 14'(FAT_BYTES));
    assign rd_addr = cmd.rd_hi ? hi_wrap[AW-1:0] : lo_wrap[AW-1:0];
    assign wr_ok   = {1'b0, addr_reg} < 14'(FAT_BYTES);

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr && wr_ok)
        begin
            fat_mem[addr_reg[AW-1:0]] <= byte_reg;
        end
        rd_data_reg <= fat_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_hi)
        begin
            lo_byte_reg <= rd_data_reg;
        end
        if (cmd.mul)
        begin
            prod_reg <= {8'd0, cluster_reg} * {12'd0, spc_eff};
        end
    end

    assign next_cluster = cluster_reg[0] ? {rd_data_reg, lo_byte_reg[7:4]}
                                         : {rd_data_reg[3:0], lo_byte_reg};
    assign sic_inc      = {1'b0, sic_reg} + 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cluster_reg <= '0;
            sic_reg     <= '0;
            sector_reg  <= '0;
        end
        else
        begin
            if (cmd.set_start)
            begin
                cluster_reg <= start_reg;
                sic_reg     <= '0;
            end
            else if (cmd.set_next)
            begin
                cluster_reg <= next_cluster;
                sic_reg     <= '0;
            end
            else if (cmd.step_in)
            begin
                sic_reg    <= sic_inc[6:0];
                sector_reg <= sector_reg + 25'd1;
            end
            if (cmd.add)
            begin
                sector_reg <= base_reg + {5'd0, prod_reg};
            end
        end
    end

    assign eoc      = cluster_reg >= CLUSTER_EOC_LO;
    assign readable = (cluster_reg >= CLUSTER_FIRST) && (cluster_reg <= last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= {1'b0, readable, eoc, sector_reg, cluster_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign stat.action     = act_reg;
    assign stat.in_cluster = sic_inc < spc_eff;
    assign stat.div_done   = div_done;
    assign stat.out_free   = !out_valid_reg || m_axis_tready;

endmodule

>>> design/fat12_cluster_chain_walker.sv
// Per accepted beat: an advance within a cluster steps the sector, then the output stage;
// a start sets the cluster, then multiply/add; an advance to the next cluster does two FAT byte
// reads from one memory port, then multiply/add. A load gives no beat. Next beat is accepted
// when the FSM is back in idle. Reset and every config write trigger a geometry recompute
// (two 21-step divides) with s_axis_tready low. Reset is async active low; position and config
// registers return to their defaults; the FAT store is undefined until loaded.
`timescale 1ns / 1ps

module fat12_cluster_chain_walker
    import fccw_pkg::*;
#(
    parameter int FAT_BYTES = FAT_BYTES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [12:0] fat_address, [20:13] fat_byte, [32:21] start_cluster, [39:33] zero
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    // [1:0] action
    input  logic [IN_USER_W-1:0]   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [11:0] cluster, [36:12] sector, [37] end_of_chain, [38] readable, [39] zero
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    fccw_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .cfg_we        (cfg_we),
        .stat          (stat),
        .cmd           (cmd)
    );

    fccw_dp #(
        .FAT_BYTES (FAT_BYTES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

>>> design/fccw_chk.sv
// Port-level checker for the cluster chain walker, bound to the top level.
// Depends on fccw_pkg and fat12_cluster_chain_walker.
`timescale 1ns / 1ps

module fccw_chk
    import fccw_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_DATA_W-1:0]   s_axis_tdata,
    input logic [IN_USER_W-1:0]   s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_DATA_W-1:0]  m_axis_tdata,
    input logic                   cfg_we,
    input logic [CFG_INDEX_W-1:0] cfg_index,
    input logic [CFG_DATA_W-1:0]  cfg_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !s_axis_tready)
        else $error("input ready right after a config write");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[37] && m_axis_tdata[38]))
        else $error("end_of_chain and readable both set");

    a_readable_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[38] |-> m_axis_tdata[11:0] >= CLUSTER_FIRST)
        else $error("readable flag on a reserved cluster");

endmodule

bind fat12_cluster_chain_walker fccw_chk u_chk (.*);

>>> bench/tb.sv
// Self-checking bench for fat12_cluster_chain_walker: FAT loads, chain starts and sector advances
// are predicted per accepted beat and compared with every result beat. Depends on fccw_pkg.
`timescale 1ns / 1ps

module tb;
    import fccw_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int FAT_DEPTH = FAT_BYTES_DEF;

    typedef struct packed {
        logic [11:0] cluster;
        logic [24:0] sector;
        logic        end_of_chain;
        logic        readable;
    } position_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CYCLIC} rx_style_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic [IN_USER_W-1:0]   s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // geometry registers as the block should hold them
    longint unsigned cfg_bps    = BPS_RST;
    longint unsigned cfg_spc    = SPC_RST;
    longint unsigned cfg_resv   = RESV_RST;
    longint unsigned cfg_copies = COPIES_RST;
    longint unsigned cfg_spf    = SPF_RST;
    longint unsigned cfg_root   = ROOT_RST;
    longint unsigned cfg_total  = TOTAL_RST;

    logic [7:0]  fat_mem [0:FAT_DEPTH-1];
    bit          fat_known [0:FAT_DEPTH-1];
    logic [11:0] cur_cluster = '0;
    logic [6:0]  cur_sic = '0;
    logic [24:0] cur_sector = '0;

    position_t positions_due[$];

    int items_sent = 0;
    int fail_count = 0;
    int tx_burst_left = 0;
    bit tx_gaps_on = 1'b1;

    int        rx_hold_req = 0;
    int        rx_hold_left = 0;
    rx_style_t rx_style = RX_OPEN;
    int        rx_style_left = 0;
    int        rx_tick = 0;

    fat12_cluster_chain_walker u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic int spc_eff();
        if (cfg_spc == 0)
        begin
            return 1;
        end
        if (cfg_spc > 128)
        begin
            return 128;
        end
        return int'(cfg_spc);
    endfunction

    function automatic longint unsigned first_data_sector();
        longint unsigned bps;
        bps = (cfg_bps == 0) ? 1 : cfg_bps;
        return (cfg_resv * bps + cfg_copies * cfg_spf * bps + cfg_root * 32) / bps;
    endfunction

    function automatic logic [24:0] cluster_base(input logic [11:0] c);
        logic [24:0] first;
        logic [24:0] cl;
        logic [24:0] sp;
        first = 25'(first_data_sector());
        cl = {13'd0, c};
        sp = 25'(spc_eff());
        return first + (cl - 25'd2) * sp;
    endfunction

    function automatic logic [11:0] fat_entry(input logic [11:0] c);
        int idx;
        logic [7:0] lo;
        logic [7:0] hi;
        idx = (3 * int'(c)) / 2;
        lo = fat_mem[idx % FAT_DEPTH];
        hi = fat_mem[(idx + 1) % FAT_DEPTH];
        return c[0] ? {hi, lo[7:4]} : {hi[3:0], lo};
    endfunction

    function automatic logic cluster_readable(input logic [11:0] c);
        longint unsigned first;
        longint unsigned data;
        longint unsigned last;
        first = first_data_sector();
        data = (first > cfg_total) ? 0 : cfg_total - first;
        last = data / spc_eff() + 1;
        if (last > CLUSTER_LAST_MAX)
        begin
            last = CLUSTER_LAST_MAX;
        end
        return (c >= CLUSTER_FIRST) && (c <= last);
    endfunction

    function automatic void track_position(input logic [1:0] act, input logic [12:0] addr,
                                           input logic [7:0] val, input logic [11:0] clus);
        position_t due;
        if (act == ACT_LOAD)
        begin
            fat_mem[addr] = val;
            fat_known[addr] = 1'b1;
            return;
        end
        if (act == ACT_START)
        begin
            cur_cluster = clus;
            cur_sic = '0;
            cur_sector = cluster_base(clus);
        end
        else if (act == ACT_ADVANCE)
        begin
            if (int'(cur_sic) + 1 < spc_eff())
            begin
                cur_sic = cur_sic + 7'd1;
                cur_sector = cur_sector + 25'd1;
            end
            else
            begin
                cur_cluster = fat_entry(cur_cluster);
                cur_sic = '0;
                cur_sector = cluster_base(cur_cluster);
            end
        end
        else
        begin
            return;
        end
        due.cluster = cur_cluster;
        due.sector = cur_sector;
        due.end_of_chain = (cur_cluster >= CLUSTER_EOC_LO);
        due.readable = cluster_readable(cur_cluster);
        positions_due.push_back(due);
    endfunction

    always @(posedge clk)
    begin : result_check
        position_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (positions_due.size() == 0)
            begin
                $error("result beat with nothing due: %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = positions_due.pop_front();
                if (m_axis_tdata[11:0] !== want.cluster)
                begin
                    $error("cluster: expected %0h, got %0h", want.cluster, m_axis_tdata[11:0]);
                    fail_count++;
                end
                if (m_axis_tdata[36:12] !== want.sector)
                begin
                    $error("sector: expected %0h, got %0h", want.sector, m_axis_tdata[36:12]);
                    fail_count++;
                end
                if (m_axis_tdata[37] !== want.end_of_chain)
                begin
                    $error("end_of_chain: expected %0b, got %0b", want.end_of_chain,
                           m_axis_tdata[37]);
                    fail_count++;
                end
                if (m_axis_tdata[38] !== want.readable)
                begin
                    $error("readable: expected %0b, got %0b", want.readable, m_axis_tdata[38]);
                    fail_count++;
                end
            end
        end
    end

    // output stall pattern; a long hold is counted down here
    always @(posedge clk)
    begin
        if (rx_hold_req > 0)
        begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_style_left == 0)
        begin
            rx_style = rx_style_t'($urandom_range(0, 3));
            rx_style_left = $urandom_range(16, 160);
        end
        else
        begin
            rx_style_left = rx_style_left - 1;
        end
        rx_tick = rx_tick + 1;
        if (rx_hold_left > 0)
        begin
            rx_hold_left = rx_hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case (rx_style)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:   m_axis_tready <= ((rx_tick % 7) < 4);
            endcase
        end
    end

    task automatic send_beat(input logic [1:0] act, input logic [12:0] addr,
                             input logic [7:0] val, input logic [11:0] clus);
        int gap;
        gap = 0;
        if (tx_burst_left == 0)
        begin
            tx_burst_left = $urandom_range(1, 20);
            if (tx_gaps_on && $urandom_range(0, 3) != 0)
            begin
                gap = $urandom_range(1, 9);
            end
        end
        tx_burst_left = tx_burst_left - 1;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, clus, val, addr};
        s_axis_tuser  <= act;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        track_position(act, addr, val, clus);
        if (act != ACT_UNUSED)
        begin
            items_sent++;
        end
    endtask

    task automatic bus_quiet();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_results();
        while (positions_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
        // covers a load still in flight and lets a previous recompute get going
        repeat (10) @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_BPS:    cfg_bps    = value & 16'h1FFF;
            CFG_SPC:    cfg_spc    = value & 16'h00FF;
            CFG_RESV:   cfg_resv   = value;
            CFG_COPIES: cfg_copies = value & 16'h00FF;
            CFG_SPF:    cfg_spf    = value;
            CFG_ROOT:   cfg_root   = value;
            CFG_TOTAL:  cfg_total  = value;
            default:    ;
        endcase
    endtask

    task automatic set_geometry(input int bps, input int spc, input int resv, input int copies,
                                input int spf, input int root, input int total);
        bus_quiet();
        wait_results();
        write_reg(CFG_BPS, 16'(bps));
        write_reg(CFG_SPC, 16'(spc));
        write_reg(CFG_RESV, 16'(resv));
        write_reg(CFG_COPIES, 16'(copies));
        write_reg(CFG_SPF, 16'(spf));
        write_reg(CFG_ROOT, 16'(root));
        write_reg(CFG_TOTAL, 16'(total));
    endtask

    // rewrite one packed 12-bit entry, keeping the neighbor's nibble
    task automatic set_fat_entry(input logic [11:0] c, input logic [11:0] val);
        int idx;
        logic [7:0] b0;
        logic [7:0] b1;
        idx = (3 * int'(c)) / 2;
        b0 = fat_known[idx] ? fat_mem[idx] : 8'($urandom_range(0, 255));
        b1 = fat_known[idx + 1] ? fat_mem[idx + 1] : 8'($urandom_range(0, 255));
        if (c[0])
        begin
            b0 = {val[3:0], b0[3:0]};
            b1 = val[11:4];
        end
        else
        begin
            b0 = val[7:0];
            b1 = {b1[7:4], val[11:8]};
        end
        send_beat(ACT_LOAD, 13'(idx), b0, 12'($urandom_range(0, 4095)));
        send_beat(ACT_LOAD, 13'(idx + 1), b1, 12'($urandom_range(0, 4095)));
    endtask

    task automatic start_chain(input logic [11:0] c);
        send_beat(ACT_START, 13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)), c);
    endtask

    // never let the block read a FAT byte that was not loaded
    task automatic advance_once();
        int idx;
        if (int'(cur_sic) + 1 >= spc_eff())
        begin
            idx = (3 * int'(cur_cluster)) / 2;
            for (int k = idx; k <= idx + 1; k++)
            begin
                if (!fat_known[k % FAT_DEPTH])
                begin
                    send_beat(ACT_LOAD, 13'(k % FAT_DEPTH), 8'($urandom_range(0, 255)),
                              12'($urandom_range(0, 4095)));
                end
            end
        end
        send_beat(ACT_ADVANCE, 13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)),
                  12'($urandom_range(0, 4095)));
    endtask

    function automatic logic [11:0] pick_cluster();
        if ($urandom_range(0, 9) == 0)
        begin
            return 12'($urandom_range(0, 4095));
        end
        return 12'($urandom_range(CLUSTER_FIRST, CLUSTER_LAST_MAX));
    endfunction

    function automatic logic [11:0] chain_tail();
        if ($urandom_range(0, 3) != 0)
        begin
            return 12'($urandom_range(CLUSTER_EOC_LO, 12'hFFF));
        end
        return 12'($urandom_range(0, 4095));
    endfunction

    task automatic walk_chain();
        logic [11:0] links [0:6];
        int len;
        int n_adv;
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
        begin
            links[i] = pick_cluster();
        end
        for (int i = 0; i < len; i++)
        begin
            set_fat_entry(links[i], (i == len - 1) ? chain_tail() : links[i + 1]);
        end
        start_chain(links[0]);
        n_adv = len * spc_eff() + $urandom_range(0, 2);
        if (n_adv > 40)
        begin
            n_adv = $urandom_range(8, 40);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            n_adv = $urandom_range(0, n_adv);
        end
        repeat (n_adv) advance_once();
    endtask

    task automatic noise_item();
        case ($urandom_range(0, 3))
            0: send_beat(ACT_LOAD, 13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)),
                         12'($urandom_range(0, 4095)));
            1: send_beat(ACT_UNUSED, 13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)),
                         12'($urandom_range(0, 4095)));
            2: start_chain(12'($urandom_range(0, 4095)));
            default: advance_once();
        endcase
    endtask

    task automatic run_traffic(input int n);
        int stop_at;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 4)) noise_item();
            end
            else
            begin
                walk_chain();
            end
        end
    endtask

    task automatic test_directed_items();
        send_beat(ACT_LOAD, 13'd0, 8'h00, 12'hFFF);
        send_beat(ACT_LOAD, 13'h1FFF, 8'hFF, 12'h000);
        send_beat(ACT_UNUSED, 13'h1FFF, 8'hFF, 12'hFFF);
        start_chain(12'd0);
        start_chain(12'd1);
        start_chain(12'd2);
        start_chain(12'd2848);
        start_chain(12'd2849);
        start_chain(CLUSTER_LAST_MAX);
        start_chain(12'hFF7);
        start_chain(CLUSTER_EOC_LO);
        start_chain(12'hFFF);
        set_fat_entry(12'd2, 12'd3);
        set_fat_entry(12'd3, 12'hFFF);
        start_chain(12'd2);
        repeat (3) advance_once();
    endtask

    task automatic test_corner_geometry();
        set_geometry(128, 1, 1, 1, 1, 1, 1);
        run_traffic(40);
        set_geometry(4096, 128, 65535, 255, 65535, 65535, 65535);
        run_traffic(40);
        set_geometry(0, 0, 1, 1, 1, 16, 65535);
        run_traffic(40);
        set_geometry(1000, 200, 3, 2, 7, 100, 40000);
        run_traffic(40);
        set_geometry(8191, 2, 0, 0, 0, 0, 0);
        run_traffic(40);
        // cluster 1 starts just below the sector wrap point
        set_geometry(512, 128, 1, 1, 1, 1, 65535);
        start_chain(12'd1);
        repeat (130) advance_once();
        set_geometry(4096, 4, 32, 2, 12, 512, 65535);
        run_traffic(40);
    endtask

    task automatic test_random_geometry();
        int bps;
        int spc;
        repeat (4)
        begin
            bps = ($urandom_range(0, 4) != 0) ? (128 << $urandom_range(0, 5))
                                              : $urandom_range(0, 8191);
            spc = ($urandom_range(0, 4) != 0) ? (1 << $urandom_range(0, 3))
                                              : $urandom_range(0, 255);
            set_geometry(bps, spc,
                         ($urandom_range(0, 3) != 0) ? $urandom_range(1, 8)
                                                     : $urandom_range(0, 65535),
                         $urandom_range(1, 3), $urandom_range(1, 16),
                         $urandom_range(16, 512), $urandom_range(100, 65535));
            run_traffic(60);
        end
    endtask

    task automatic test_output_backpressure();
        tx_gaps_on = 1'b0;
        rx_hold_req = 400;
        run_traffic(60);
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        run_traffic(25);
        bus_quiet();
        wait_results();
        run_traffic(25);
    endtask

    initial
    begin
        int drain_wait;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_items();
        test_corner_geometry();
        test_random_geometry();
        test_output_backpressure();
        test_drain_pause();
        bus_quiet();
        drain_wait = 0;
        while (positions_due.size() != 0 && drain_wait < 20000)
        begin
            @(posedge clk);
            drain_wait++;
        end
        if (positions_due.size() != 0)
        begin
            $error("%0d results never arrived", positions_due.size());
            fail_count++;
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
design/fccw_pkg.sv
design/fccw_div.sv
design/fccw_ctrl.sv
design/fccw_dp.sv
design/fat12_cluster_chain_walker.sv
design/fccw_chk.sv
bench/tb.sv
